[rtl/rmv_pkg.sv]
// Shared types and constants for the running mean and variance block.
package rmv_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int MAX_BLOCK_DEF   = 4096;

    // Block size register
    localparam int                CFG_W          = 13;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = CFG_W'(1);

    // Fractional bits of the results
    localparam int FRAC_MEAN = 8;
    localparam int FRAC_VAR  = 16;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_START_M,
        ST_RUN_M,
        ST_START_V,
        ST_RUN_V,
        ST_SQR,
        ST_HOLD
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // capture the input sample
        logic accumulate;   // update sums, count and block position
        logic start_mean;   // load divider with the mean division
        logic start_var;    // load divider with the second-moment division
        logic take_mean;    // capture mean quotient
        logic take_var;     // capture second-moment quotient
        logic square;       // square the mean magnitude
        logic load_out;     // load the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic emit;         // this sample closes a block
        logic div_busy;     // divider still iterating
    } t_status;

endpackage

[rtl/running_mean_variance.sv]
// Non-emitting sample: capture, then accumulate. Emitting sample: capture, accumulate, then
// the shared one-bit-per-cycle divider runs SAMPLE_BITS+8 steps for the mean and
// 2*SAMPLE_BITS+15 for the second moment, then squaring and the load of the output register.
// One sample in flight at a time; a finished result waits in the output register while the
// next samples are taken. Synchronous active-low reset clears sums, count, overflow flag and
// block position and sets block_size to 1; no clearing pass.
module running_mean_variance #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rmv_pkg::COUNT_BITS_DEF,
    parameter int MAX_BLOCK   = rmv_pkg::MAX_BLOCK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rmv_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_BITS+7:0]   o_mean_q8,
    output logic [2*SAMPLE_BITS+14:0]       o_variance_q16,
    output logic [COUNT_BITS-1:0]           o_sample_count,
    output logic                            o_overflow
);
    import rmv_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rmv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rmv_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .o_mean_q8      (o_mean_q8),
        .o_variance_q16 (o_variance_q16),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

endmodule

[rtl/rmv_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit the step count.
module rmv_div #(
    parameter int DVD_W  = 70,
    parameter int Q_W    = 47,
    parameter int STEP_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVD_W-1:0]  i_divisor,   // divisor already shifted to the top quotient bit
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_busy,
    output logic [Q_W-1:0]    o_quotient
);

    logic              r_busy, n_busy;
    logic [DVD_W-1:0]  r_rem, n_rem;
    logic [DVD_W-1:0]  r_dsr, n_dsr;
    logic [Q_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              w_ge;

    assign w_ge = (r_rem >= r_dsr);

    // Load on start, then subtract-and-shift each cycle
    always_comb begin
        n_busy = r_busy;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = i_dividend;
            n_dsr  = i_divisor;
            n_quo  = '0;
            n_cnt  = i_steps;
        end else if (r_busy) begin
            if (w_ge) begin
                n_rem = r_rem - r_dsr;
            end
            n_quo = {r_quo[Q_W-2:0], w_ge};
            n_dsr = r_dsr >> 1;
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[rtl/rmv_dpath.sv]
// Datapath: accumulators, block position, shared divider, squarer and output register.
module rmv_dpath #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rmv_pkg::t_cmd                       i_cmd,
    output rmv_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [rmv_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic signed [SAMPLE_BITS+7:0]       o_mean_q8,
    output logic [2*SAMPLE_BITS+14:0]           o_variance_q16,
    output logic [COUNT_BITS-1:0]               o_sample_count,
    output logic                                o_overflow
);
    import rmv_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
    localparam int MEAN_W = SAMPLE_BITS + FRAC_MEAN;
    localparam int VAR_W  = 2 * SAMPLE_BITS - 1 + FRAC_VAR;
    localparam int DVD_W  = SQ_W + FRAC_VAR;
    localparam int STEP_W = $clog2(VAR_W + 1);
    localparam int POS_W  = $clog2(MAX_BLOCK + 1);

    // Accumulator state
    logic signed [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]               r_sumsq;
    logic [COUNT_BITS-1:0]         r_count;
    logic [POS_W-1:0]              r_pos;
    logic                          r_ovf;
    logic [CFG_W-1:0]              r_cfg;
    logic signed [SAMPLE_BITS-1:0] r_smp;

    // Result pipeline
    logic [MEAN_W-1:0]   r_qmean;
    logic [VAR_W-1:0]    r_a;
    logic [2*MEAN_W-1:0] r_m2;

    logic signed [2*SAMPLE_BITS-1:0] w_sq;
    logic                            w_full;
    logic [POS_W-1:0]                w_eff;
    logic [POS_W-1:0]                w_pos_inc;
    logic                            w_emit;
    logic [SUM_W-1:0]                w_mag;
    logic [DVD_W-1:0]                w_dvd;
    logic [DVD_W-1:0]                w_dsr;
    logic [STEP_W-1:0]               w_steps;
    logic                            w_div_busy;
    logic [VAR_W-1:0]                w_quo;
    logic [MEAN_W-1:0]               w_mean;
    logic [VAR_W-1:0]                w_var;
    logic                            w_cnt_zero;

    // Effective block size: zero reads as one, large values saturate
    always_comb begin
        if (r_cfg == '0) begin
            w_eff = POS_W'(1);
        end else if (32'(r_cfg) > 32'(MAX_BLOCK)) begin
            w_eff = POS_W'(MAX_BLOCK);
        end else begin
            w_eff = POS_W'(r_cfg);
        end
    end

    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_emit    = (w_pos_inc >= w_eff);
    assign w_sq      = r_smp * r_smp;
    assign w_full    = &r_count;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= BLOCK_SIZE_RST;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_smp <= i_sample;
        end
    end

    // Running sums, count, overflow flag and block position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accumulate) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_sum   <= r_sum + SUM_W'(r_smp);
                r_sumsq <= r_sumsq + SQ_W'($unsigned(w_sq));
                r_count <= r_count + COUNT_BITS'(1);
            end
            r_pos <= w_emit ? '0 : w_pos_inc;
        end
    end

    // Divider operands: |sum|<<8 / n or sumsq<<16 / n
    assign w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_comb begin
        if (i_cmd.start_var) begin
            w_dvd   = DVD_W'(r_sumsq) << FRAC_VAR;
            w_dsr   = DVD_W'(r_count) << (VAR_W - 1);
            w_steps = STEP_W'(VAR_W);
        end else begin
            w_dvd   = DVD_W'(w_mag) << FRAC_MEAN;
            w_dsr   = DVD_W'(r_count) << (MEAN_W - 1);
            w_steps = STEP_W'(MEAN_W);
        end
    end

    rmv_div #(
        .DVD_W  (DVD_W),
        .Q_W    (VAR_W),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_mean | i_cmd.start_var),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .i_steps    (w_steps),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Quotient capture and squaring of the mean magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_mean) begin
            r_qmean <= w_quo[MEAN_W-1:0];
        end
        if (i_cmd.take_var) begin
            r_a <= w_quo;
        end
        if (i_cmd.square) begin
            r_m2 <= r_qmean * r_qmean;
        end
    end

    // Final sign, variance subtract with clamp at zero
    assign w_cnt_zero = (r_count == '0);
    assign w_mean     = r_sum[SUM_W-1] ? MEAN_W'(-r_qmean) : r_qmean;
    assign w_var      = ((2*MEAN_W)'(r_a) > r_m2) ? (r_a - VAR_W'(r_m2)) : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mean_q8      <= w_cnt_zero ? '0 : $signed(w_mean);
            o_variance_q16 <= w_cnt_zero ? '0 : w_var;
            o_sample_count <= r_count;
            o_overflow     <= r_ovf;
        end
    end

    assign o_status.emit     = w_emit;
    assign o_status.div_busy = w_div_busy;

endmodule

[rtl/rmv_ctrl.sv]
// Controller state machine: sequences accumulation, divisions, squaring and output handoff.
module rmv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  rmv_pkg::t_status  i_status,
    output rmv_pkg::t_cmd     o_cmd
);
    import rmv_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state = i_status.emit ? ST_START_M : ST_IDLE;
            end
            ST_START_M: begin
                o_cmd.start_mean = 1'b1;
                n_state = ST_RUN_M;
            end
            ST_RUN_M: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_mean = 1'b1;
                    n_state = ST_START_V;
                end
            end
            ST_START_V: begin
                o_cmd.start_var = 1'b1;
                n_state = ST_RUN_V;
            end
            ST_RUN_V: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_var = 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.square = 1'b1;
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/rmv_check.sv]
// Port-level checker for the running mean and variance block, with its bind.
module rmv_check #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS+7:0] o_mean_q8,
    input logic [2*SAMPLE_BITS+14:0]     o_variance_q16,
    input logic [COUNT_BITS-1:0]         o_sample_count,
    input logic                          o_overflow
);

    // Pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before its transaction");

    // Stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_mean_q8) && $stable(o_variance_q16)
            && $stable(o_sample_count) && $stable(o_overflow))
        else $error("result changed while stalled");

    // One sample at a time: input closes after each transaction
    a_in_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input still open after a transaction");

    // Overflow only once the count is saturated
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> (o_sample_count == {COUNT_BITS{1'b1}}))
        else $error("overflow flagged below count limit");

    // A new result appears only after the input side was closed for computation
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without a computation pass");

endmodule

bind running_mean_variance rmv_check #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_rmv_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_mean_q8      (o_mean_q8),
    .o_variance_q16 (o_variance_q16),
    .o_sample_count (o_sample_count),
    .o_overflow     (o_overflow)
);

[sim/running_mean_variance_test.sv]
// Self-checking testbench for running_mean_variance with a cycle-free statistics tracker.
module running_mean_variance_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmv_pkg::*;

    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int COUNT_W   = COUNT_BITS_DEF;
    localparam int MEAN_W    = SAMPLE_W + FRAC_MEAN;
    localparam int VAR_W     = 2*SAMPLE_W + 15;
    localparam int MAX_POS   = 2**(SAMPLE_W-1) - 1;
    localparam int MIN_NEG   = -(2**(SAMPLE_W-1));
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_W) - 64'd1;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 120;
    localparam int HOLD_CYCLES   = 2000;
    localparam int HOLD_PHASE    = 1;
    localparam int NUM_PHASES    = 11;
    localparam int RUN_LIMIT_NS  = 60_000_000;

    typedef struct {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [VAR_W-1:0]         variance_q16;
        logic [COUNT_W-1:0]       sample_count;
        logic                     overflow;
    } t_stats;

    // Tracks the running sums and queues the statistics each closed block should report
    class t_mean_var_tracker;
        longint               acc_sum;
        longint unsigned      acc_sq;
        longint unsigned      n_samples;
        int unsigned          blk_pos;
        bit                   ovf_seen;
        logic [CFG_W-1:0]     blk_size;
        t_stats               expected_stats[$];
        int                   fails;

        function new();
            acc_sum   = 0;
            acc_sq    = 0;
            n_samples = 0;
            blk_pos   = 0;
            ovf_seen  = 1'b0;
            blk_size  = BLOCK_SIZE_RST;
            fails     = 0;
        endfunction

        function void set_block_size(logic [CFG_W-1:0] v);
            blk_size = v;
        endfunction

        function int waiting();
            return expected_stats.size();
        endfunction

        // Zero means one; anything past the maximum saturates
        function int unsigned eff_block();
            if (blk_size == 0) begin
                return 1;
            end
            if (blk_size > MAX_BLOCK_DEF) begin
                return MAX_BLOCK_DEF;
            end
            return blk_size;
        endfunction

        function t_stats current_stats();
            t_stats          st;
            bit              neg;
            longint unsigned mag, q, qs, rs, a, m2;
            st.mean_q8      = '0;
            st.variance_q16 = '0;
            if (n_samples != 0) begin
                neg = (acc_sum < 0);
                if (neg) begin
                    mag = 0 - acc_sum;
                end else begin
                    mag = acc_sum;
                end
                q = (mag << FRAC_MEAN) / n_samples;
                st.mean_q8 = neg ? MEAN_W'(64'd0 - q) : MEAN_W'(q);
                // second moment split so the shift cannot lose bits
                qs = acc_sq / n_samples;
                rs = acc_sq % n_samples;
                a  = (qs << FRAC_VAR) + ((rs << FRAC_VAR) / n_samples);
                m2 = q * q;
                st.variance_q16 = (a > m2) ? VAR_W'(a - m2) : '0;
            end
            st.sample_count = COUNT_W'(n_samples);
            st.overflow     = ovf_seen;
            return st;
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            longint sv;
            sv = s;
            // at the count limit the sample only advances the block
            if (n_samples >= COUNT_LIMIT) begin
                ovf_seen = 1'b1;
            end else begin
                acc_sum   += sv;
                acc_sq    += sv * sv;
                n_samples += 1;
            end
            blk_pos++;
            if (blk_pos >= eff_block()) begin
                blk_pos = 0;
                expected_stats.insert(expected_stats.size(), current_stats());
            end
        endfunction

        function void check_stats(t_stats got);
            t_stats want;
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result mean_q8 %0d variance_q16 %0d count %0d",
                         $time, got.mean_q8, got.variance_q16, got.sample_count);
                fails++;
                return;
            end
            want = expected_stats.pop_front();
            if (got.mean_q8 !== want.mean_q8) begin
                $display("%0t: mean_q8 expected %0d actual %0d",
                         $time, want.mean_q8, got.mean_q8);
                fails++;
            end
            if (got.variance_q16 !== want.variance_q16) begin
                $display("%0t: variance_q16 expected %0d actual %0d",
                         $time, want.variance_q16, got.variance_q16);
                fails++;
            end
            if (got.sample_count !== want.sample_count) begin
                $display("%0t: sample_count expected %0d actual %0d",
                         $time, want.sample_count, got.sample_count);
                fails++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                fails++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic signed [SAMPLE_W-1:0]  i_sample = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic signed [MEAN_W-1:0]    o_mean_q8;
    logic [VAR_W-1:0]            o_variance_q16;
    logic [COUNT_W-1:0]          o_sample_count;
    logic                        o_overflow;

    bit                hold_sink_req = 1'b0;
    t_mean_var_tracker book = new();

    // Block size per phase, with the extremes and a shrink from the maximum
    int phase_blk [NUM_PHASES] = '{0, 2, 3, 16, 5, 4096, 3, 1, 7, 8191, 1};
    int phase_len [NUM_PHASES] = '{110, 140, 90, 120, 80, 100, 70, 120, 60, 60, 80};
    int directed_samples [16] = '{32767, 32767, -32768, -32768, 0, -1, 1, 21845,
                                  -21846, 32767, 32767, 32767, -32768, -32768, -32768, 0};

    running_mean_variance DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mean_q8      (o_mean_q8),
        .o_variance_q16 (o_variance_q16),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(1, 3);
        end
        if (r < 93) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r, x;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            x = $urandom();
        end else if (r < 72) begin
            case ($urandom_range(0, 3))
                0: x = MAX_POS;
                1: x = MIN_NEG;
                2: x = -1;
                default: x = 0;
            endcase
        end else if (r < 85) begin
            x = int'($urandom_range(0, 16)) - 8;
        end else if ($urandom_range(0, 1)) begin
            x = MAX_POS - int'($urandom_range(0, 255));
        end else begin
            x = MIN_NEG + int'($urandom_range(0, 255));
        end
        return SAMPLE_W'(x);
    endfunction

    // Observe every transaction and config write at the clock edge
    always @(posedge i_clk) begin
        t_stats got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                book.set_block_size(i_cfg_data);
            end
            if (i_valid && o_ready) begin
                book.take_sample(i_sample);
            end
            if (o_valid && i_ready) begin
                got.mean_q8      = o_mean_q8;
                got.variance_q16 = o_variance_q16;
                got.sample_count = o_sample_count;
                got.overflow     = o_overflow;
                book.check_stats(got);
            end
        end
    end

    // Result side: random back-pressure, long ready stretches, one long hold-off
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_sink_req) begin
                hold_sink_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 300)) @(posedge i_clk);
            end
            if ($urandom_range(0, 1)) begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    // Offer one sample and hold it until o_ready is sampled high on the clock
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic pause_input(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every queued result, then for the last accumulate
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (book.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_size(input logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Main stimulus
    initial begin
        int p, k;
        bit no_gaps;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed extremes at the reset block size of one
        for (k = 0; k < 16; k++) begin
            send_sample(SAMPLE_W'(directed_samples[k]));
            if (k % 3 == 2) begin
                pause_input(idle_len());
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            write_block_size(CFG_W'(phase_blk[p]));
            no_gaps = ($urandom_range(0, 2) == 0);
            for (k = 0; k < phase_len[p]; k++) begin
                if (p == HOLD_PHASE && k == 20) begin
                    hold_sink_req = 1'b1;
                end
                send_sample(pick_sample());
                if (!no_gaps && $urandom_range(0, 1)) begin
                    pause_input(idle_len());
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.fails == 0) begin
            $display("running_mean_variance: match");
        end else begin
            $display("running_mean_variance: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("running_mean_variance: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/rmv_pkg.sv
rtl/rmv_div.sv
rtl/rmv_dpath.sv
rtl/rmv_ctrl.sv
rtl/running_mean_variance.sv
rtl/rmv_check.sv
sim/running_mean_variance_test.sv
